// ===== rtl/core/abdc_pkg.sv =====
`timescale 1ns / 1ps

package abdc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_VERSION = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILE_TYPE      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILE_SIZE      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEADING_CHECK  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRAILING_CHECK = 3'd4;

   localparam logic [31:0] MAGIC_BASE      = 32'd20040308;
   localparam logic [31:0] FILE_TYPE_RESET = 32'd1;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_VERSION_BAD = 3'd1;
   localparam logic [2:0] STATUS_TYPE_ZERO   = 3'd2;
   localparam logic [2:0] STATUS_CHECK_DIFF  = 3'd3;
   localparam logic [2:0] STATUS_SUM_BAD     = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       final_res;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] header_version;
      logic [31:0] file_type;
      logic [31:0] file_size;
      logic [7:0]  leading_check;
      logic [7:0]  trailing_check;
   } cfg_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic [7:0] sum;
   } step_type;

endpackage

// ===== rtl/core/abdc_stream.sv =====
`timescale 1ns / 1ps

module abdc_stream (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              type_write,
   input  logic [7:0]        type_write_low,
   input  logic [31:0]       file_type,
   input  abdc_pkg::req_type req,
   output abdc_pkg::step_type step
);
   import abdc_pkg::*;

   logic [7:0]  position_ff, position_in;
   logic [31:0] period_ff, period_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  plain;
   logic [7:0]  type_low;

   always_comb begin
      type_low    = file_type[7:0];
      sum_in      = sum_ff + req.data_byte;
      plain       = req.data_byte - position_ff;
      position_in = position_ff + 8'd1;
      period_in   = '0;
      if (file_type != '0) begin
         if (period_ff == '0) begin
            plain = plain - type_low;
         end
         if (period_ff >= file_type - 32'd1) begin
            period_in = '0;
         end else begin
            period_in = period_ff + 32'd1;
         end
      end
      step.plain_byte = plain;
      step.sum        = sum_in;
      // end of file restarts the stream
      if (req.last_byte) begin
         position_in = '0;
         period_in   = '0;
         sum_in      = type_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         period_ff   <= '0;
         sum_ff      <= FILE_TYPE_RESET[7:0];
      end else if (type_write) begin
         position_ff <= '0;
         period_ff   <= '0;
         sum_ff      <= type_write_low;
      end else if (accept) begin
         position_ff <= position_in;
         period_ff   <= period_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

// ===== rtl/core/abdc_check.sv =====
`timescale 1ns / 1ps

module abdc_check (
   input  abdc_pkg::cfg_type cfg,
   input  logic [7:0]        sum,
   input  logic              last_byte,
   output logic [2:0]        status
);
   import abdc_pkg::*;

   logic [31:0] expected_version;

   always_comb begin
      expected_version = MAGIC_BASE + cfg.file_type + cfg.file_size;
      priority if (!last_byte) begin
         status = STATUS_OK;
      end else if (cfg.header_version != expected_version) begin
         status = STATUS_VERSION_BAD;
      end else if (cfg.file_type == '0) begin
         status = STATUS_TYPE_ZERO;
      end else if (cfg.leading_check != cfg.trailing_check) begin
         status = STATUS_CHECK_DIFF;
      end else if (cfg.leading_check != sum) begin
         status = STATUS_SUM_BAD;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

// ===== rtl/core/additive_byte_descrambler_check.sv =====
`timescale 1ns / 1ps

// Additive byte descrambler with file check.
// Request channel (req_valid/req_ready/req_payload) takes one scrambled
// payload byte per request, with last_byte on the final byte of a file.
// Response channel (rsp_valid/rsp_ready/rsp_payload) returns one result per
// request: the plain byte, and on the last byte final_res with a status
// (ok, version bad, type zero, check bytes differ, sum mismatch).
// The response is registered: a request accepted at one edge shows its
// response after that edge. Throughput is one request per cycle while the
// receiver takes responses, set by the single response register; the
// stream state updates in the same cycle. When the receiver stalls, the
// response register holds and req_ready drops until it is taken; a request
// is still taken in the cycle it is unloaded. The csr port writes the five
// header registers; a write of file_type restarts the stream, as does the
// end of every file. Reset (synchronous) clears the header registers, sets
// file_type to 1 and the running sum to 1, and empties the response register.

module additive_byte_descrambler_check (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  abdc_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output abdc_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [abdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [abdc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import abdc_pkg::*;

   cfg_type  cfg_ff;
   step_type step;
   logic     accept;
   logic     type_write;
   logic [2:0] status;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign type_write = csr_write_enable && (csr_index == CSR_FILE_TYPE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_version <= '0;
         cfg_ff.file_type      <= FILE_TYPE_RESET;
         cfg_ff.file_size      <= '0;
         cfg_ff.leading_check  <= '0;
         cfg_ff.trailing_check <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEADER_VERSION: cfg_ff.header_version <= csr_write_data;
            CSR_FILE_TYPE:      cfg_ff.file_type      <= csr_write_data;
            CSR_FILE_SIZE:      cfg_ff.file_size      <= csr_write_data;
            CSR_LEADING_CHECK:  cfg_ff.leading_check  <= csr_write_data[7:0];
            CSR_TRAILING_CHECK: cfg_ff.trailing_check <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   abdc_stream u_stream (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .type_write     (type_write),
      .type_write_low (csr_write_data[7:0]),
      .file_type      (cfg_ff.file_type),
      .req            (req_payload),
      .step           (step)
   );

   abdc_check u_check (
      .cfg       (cfg_ff),
      .sum       (step.sum),
      .last_byte (req_payload.last_byte),
      .status    (status)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.plain_byte <= step.plain_byte;
         rsp_ff.final_res  <= req_payload.last_byte;
         rsp_ff.status     <= status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request refused with empty response register");

   a_last_gives_final: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.last_byte |=> rsp_valid && rsp_payload.final_res)
      else $error("last byte did not produce a final response");

   a_status_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.final_res |-> rsp_payload.status == STATUS_OK)
      else $error("status set on a non-final response");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
